>>> src/prq_pkg.sv
// Shared types and constants for the priority ready queue.
`default_nettype none

package prq_pkg;

	// Default sizes handed to the top level parameters.
	localparam int unsigned QueueDepthDef    = 16;
	localparam int unsigned IdWidthDef       = 8;
	localparam int unsigned PriorityWidthDef = 8;

	// Input mode codes carried on the slave-side tuser.
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	// Result status codes carried on the master-side tuser.
	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Operation broadcast to every cell of the row in the cycle of a transfer.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/prq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
`default_nettype none

module prq_cell #(
	parameter int unsigned ID_WIDTH       = prq_pkg::IdWidthDef,
	parameter int unsigned PRIORITY_WIDTH = prq_pkg::PriorityWidthDef
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  prq_pkg::cell_ctrl_t       ctrl,
	input  wire  [ID_WIDTH-1:0]       new_id,
	input  wire  [PRIORITY_WIDTH-1:0] new_pri,
	// Neighbor toward the head.
	input  wire                       left_valid,
	input  wire  [ID_WIDTH-1:0]       left_id,
	input  wire  [PRIORITY_WIDTH-1:0] left_pri,
	input  wire                       left_keep,
	// Neighbor toward the tail.
	input  wire                       right_valid,
	input  wire  [ID_WIDTH-1:0]       right_id,
	input  wire  [PRIORITY_WIDTH-1:0] right_pri,
	// Held entry, seen by both neighbors, and insert decision, seen by the neighbor toward the tail.
	output logic                      valid,
	output logic [ID_WIDTH-1:0]       id,
	output logic [PRIORITY_WIDTH-1:0] pri,
	output logic                      keep
);

	logic                      valid_q;
	logic [ID_WIDTH-1:0]       id_q;
	logic [PRIORITY_WIDTH-1:0] pri_q;

	// An entry stays in place on insert when it ranks at or above the new one.
	assign keep  = valid_q && (pri_q >= new_pri);
	assign valid = valid_q;
	assign id    = id_q;
	assign pri   = pri_q;

	// Occupancy: shift toward the tail on insert, toward the head on remove.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end else if (ctrl.rem) begin
			valid_q <= right_valid;
		end
	end

	// Entry payload follows the same moves as the occupancy bit.
	always_ff @(posedge clk) begin
		if (ctrl.ins && !keep) begin
			if (left_keep) begin
				id_q  <= new_id;
				pri_q <= new_pri;
			end else begin
				id_q  <= left_id;
				pri_q <= left_pri;
			end
		end else if (ctrl.rem) begin
			id_q  <= right_id;
			pri_q <= right_pri;
		end
	end

endmodule

`default_nettype wire

>>> src/priority_ready_queue.sv
// Top level of the priority ready queue: handshakes, count and the row of cells.
//
// A queue of process identifiers held in descending priority order, first in,
// first out among equal priorities. Each slave-side transfer is one operation:
// insert (tuser 0) or remove the head (tuser 1). Every operation gives exactly
// one result transfer with a status, the removed entry and the count after the
// operation. The block takes one operation per clock cycle while the master
// side accepts results; its result appears on the master side in the cycle after
// the transfer. This rests on the row of QUEUE_DEPTH cells, which compare against
// the new priority in parallel and shift by one slot together. A result register
// sits between the two sides, so while a result waits a new operation is taken
// only in the same cycle that result is taken. An insert into a full queue and a
// remove from an empty one leave the queue unchanged and report their own status.
`default_nettype none

module priority_ready_queue #(
	parameter int unsigned QUEUE_DEPTH    = prq_pkg::QueueDepthDef,
	parameter int unsigned ID_WIDTH       = prq_pkg::IdWidthDef,
	parameter int unsigned PRIORITY_WIDTH = prq_pkg::PriorityWidthDef,
	localparam int unsigned CountWidth    = $clog2(QUEUE_DEPTH + 1),
	localparam int unsigned InWidth       = ((ID_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
	localparam int unsigned OutWidth      =
		((ID_WIDTH + PRIORITY_WIDTH + CountWidth + 7) / 8) * 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [InWidth-1:0]  s_tdata,  // proc_id, priority_req, zero pad
	input  wire                 s_tuser,  // mode
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [OutWidth-1:0] m_tdata,  // head_id, head_priority, queue_count, zero pad
	output logic [1:0]          m_tuser   // status
);

	localparam int unsigned PadWidth = OutWidth - ID_WIDTH - PRIORITY_WIDTH - CountWidth;

	logic                      xfer;
	prq_pkg::mode_t            mode;
	logic [ID_WIDTH-1:0]       proc_id;
	logic [PRIORITY_WIDTH-1:0] priority_req;
	logic                      full;
	logic                      empty;
	prq_pkg::cell_ctrl_t       ctrl;

	logic [CountWidth-1:0]     count_q;
	logic                      out_valid_q;
	prq_pkg::status_t          status_q;
	logic [ID_WIDTH-1:0]       head_id_q;
	logic [PRIORITY_WIDTH-1:0] head_pri_q;
	logic [CountWidth-1:0]     out_count_q;

	logic                      cell_valid [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0]       cell_id    [QUEUE_DEPTH];
	logic [PRIORITY_WIDTH-1:0] cell_pri   [QUEUE_DEPTH];
	logic                      cell_keep  [QUEUE_DEPTH];

	// Unpack the operation.
	assign mode         = prq_pkg::mode_t'(s_tuser);
	assign proc_id      = s_tdata[ID_WIDTH-1:0];
	assign priority_req = s_tdata[ID_WIDTH+PRIORITY_WIDTH-1:ID_WIDTH];

	// Accept whenever the result register is free or being drained.
	assign s_tready = !out_valid_q || m_tready;
	assign xfer     = s_tvalid && s_tready;

	assign full  = (count_q == CountWidth'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	// Operations that change the row; refused ones leave it untouched.
	assign ctrl.ins = xfer && (mode == prq_pkg::MODE_INSERT) && !full;
	assign ctrl.rem = xfer && (mode == prq_pkg::MODE_REMOVE) && !empty;

	// The row of cells, slot 0 at the head.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                      l_valid;
		logic [ID_WIDTH-1:0]       l_id;
		logic [PRIORITY_WIDTH-1:0] l_pri;
		logic                      l_keep;
		logic                      r_valid;
		logic [ID_WIDTH-1:0]       r_id;
		logic [PRIORITY_WIDTH-1:0] r_pri;

		// The head cell sees a neighbor that always keeps, so it takes the new entry.
		if (i == 0) begin : g_head
			assign l_valid = 1'b1;
			assign l_id    = '0;
			assign l_pri   = '0;
			assign l_keep  = 1'b1;
		end else begin : g_mid
			assign l_valid = cell_valid[i-1];
			assign l_id    = cell_id[i-1];
			assign l_pri   = cell_pri[i-1];
			assign l_keep  = cell_keep[i-1];
		end

		// The tail cell empties on remove.
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_id    = '0;
			assign r_pri   = '0;
		end else begin : g_body
			assign r_valid = cell_valid[i+1];
			assign r_id    = cell_id[i+1];
			assign r_pri   = cell_pri[i+1];
		end

		prq_cell #(
			.ID_WIDTH       (ID_WIDTH),
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_id      (proc_id),
			.new_pri     (priority_req),
			.left_valid  (l_valid),
			.left_id     (l_id),
			.left_pri    (l_pri),
			.left_keep   (l_keep),
			.right_valid (r_valid),
			.right_id    (r_id),
			.right_pri   (r_pri),
			.valid       (cell_valid[i]),
			.id          (cell_id[i]),
			.pri         (cell_pri[i]),
			.keep        (cell_keep[i])
		);
	end

	// Number of held entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ins) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.rem) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, formed from the state before the operation.
	always_ff @(posedge clk) begin
		if (xfer) begin
			status_q    <= prq_pkg::STATUS_DONE;
			head_id_q   <= '0;
			head_pri_q  <= '0;
			out_count_q <= count_q;
			unique case (mode)
				prq_pkg::MODE_INSERT: begin
					if (full) begin
						status_q <= prq_pkg::STATUS_FULL;
					end else begin
						out_count_q <= count_q + 1'b1;
					end
				end
				prq_pkg::MODE_REMOVE: begin
					if (empty) begin
						status_q <= prq_pkg::STATUS_EMPTY;
					end else begin
						head_id_q   <= cell_id[0];
						head_pri_q  <= cell_pri[0];
						out_count_q <= count_q - 1'b1;
					end
				end
				default: begin
					status_q <= prq_pkg::STATUS_DONE;
				end
			endcase
		end
	end

	// Pack the result.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	if (PadWidth > 0) begin : g_pad
		assign m_tdata = {{PadWidth{1'b0}}, out_count_q, head_pri_q, head_id_q};
	end else begin : g_nopad
		assign m_tdata = {out_count_q, head_pri_q, head_id_q};
	end

endmodule

`default_nettype wire

>>> tb/priority_ready_queue_test.sv
// Self-checking testbench for the priority ready queue: stream stimulus and a queue predictor.

module priority_ready_queue_test;

	localparam int unsigned Depth     = prq_pkg::QueueDepthDef;
	localparam int unsigned IdW       = prq_pkg::IdWidthDef;
	localparam int unsigned PriW      = prq_pkg::PriorityWidthDef;
	localparam int unsigned CntW      = $clog2(Depth + 1);
	localparam int unsigned InW       = ((IdW + PriW + 7) / 8) * 8;
	localparam int unsigned OutW      = ((IdW + PriW + CntW + 7) / 8) * 8;
	localparam int unsigned RandomOps = 1435;
	localparam int unsigned HoldOff   = 300;
	localparam int unsigned IdleLimit = 5000;

	// Predicts the queue contents and the result of every operation it is told about.
	class ready_queue_model;
		typedef struct {
			prq_pkg::status_t status;
			logic [IdW-1:0]   head_id;
			logic [PriW-1:0]  head_pri;
			logic [CntW-1:0]  count;
		} op_result_t;

		logic [IdW-1:0]  ids[Depth];
		logic [PriW-1:0] pris[Depth];
		int unsigned     held;
		op_result_t      pending_results[$];
		int unsigned     failures;

		function new();
			held = 0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		// Applies one accepted operation and queues the result it must give.
		function void note_operation(prq_pkg::mode_t mode, logic [IdW-1:0] id,
			logic [PriW-1:0] pri);
			op_result_t r;
			int unsigned pos;
			int unsigned i;
			r.status = prq_pkg::STATUS_DONE;
			r.head_id = '0;
			r.head_pri = '0;
			if (mode == prq_pkg::MODE_INSERT) begin
				if (held == Depth) begin
					r.status = prq_pkg::STATUS_FULL;
				end else begin
					// Equal priorities stay first in, first out.
					pos = 0;
					while (pos < held && pris[pos] >= pri)
						pos++;
					for (i = held; i > pos; i--) begin
						ids[i] = ids[i-1];
						pris[i] = pris[i-1];
					end
					ids[pos] = id;
					pris[pos] = pri;
					held++;
				end
			end else begin
				if (held == 0) begin
					r.status = prq_pkg::STATUS_EMPTY;
				end else begin
					r.head_id = ids[0];
					r.head_pri = pris[0];
					for (i = 0; i + 1 < held; i++) begin
						ids[i] = ids[i+1];
						pris[i] = pris[i+1];
					end
					held--;
				end
			end
			r.count = held[CntW-1:0];
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
				failures++;
			end
		endfunction

		// Checks one result transfer against the oldest prediction.
		function void check_result(logic [1:0] status, logic [OutW-1:0] data);
			op_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0h data %0h",
					$time, status, data);
				failures++;
				return;
			end
			e = pending_results.pop_front();
			compare_field("status", 32'(e.status), 32'(status));
			compare_field("head_id", 32'(e.head_id), 32'(data[IdW-1:0]));
			compare_field("head_priority", 32'(e.head_pri), 32'(data[IdW+PriW-1:IdW]));
			compare_field("queue_count", 32'(e.count), 32'(data[IdW+PriW+CntW-1:IdW+PriW]));
			compare_field("tdata padding", 32'd0, 32'(data[OutW-1:IdW+PriW+CntW]));
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [InW-1:0]  s_tdata = '0;
	logic            s_tuser = 1'b0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;
	logic [1:0]      m_tuser;

	ready_queue_model model = new();
	bit               hold_request = 1'b0;
	int unsigned      burst_left = 0;
	int unsigned      idle_cycles = 0;

	priority_ready_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Results are checked before the input transfer of the same edge is noted.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			model.check_result(m_tuser, m_tdata);
		if (s_tvalid && s_tready)
			model.note_operation(prq_pkg::mode_t'(s_tuser), s_tdata[IdW-1:0],
				s_tdata[IdW+PriW-1:IdW]);
	end

	// The run ends if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IdleLimit) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, IdleLimit);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: ready runs and stalls of random length, long ready stretches, long holds on request.
	initial begin
		int unsigned run_len;
		int unsigned stall_len;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HoldOff) @(posedge clk);
				hold_request = 1'b0;
			end
			run_len = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
			stall_len = $urandom_range(0, 6);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Offers one operation and returns at the edge of its transfer.
	task automatic send_op(prq_pkg::mode_t mode, logic [IdW-1:0] id, logic [PriW-1:0] pri);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= InW'({pri, id});
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Sends in bursts with random gaps between them.
	task automatic offer(prq_pkg::mode_t mode, logic [IdW-1:0] id, logic [PriW-1:0] pri);
		send_op(mode, id, pri);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// One edge passes first so that the transfer just made has been noted.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (model.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_op(int unsigned insert_pct);
		prq_pkg::mode_t mode;
		logic [PriW-1:0] pri;
		mode = ($urandom_range(1, 100) <= insert_pct) ? prq_pkg::MODE_INSERT
			: prq_pkg::MODE_REMOVE;
		// Half the priorities come from a coarse set so that ties are common.
		if ($urandom_range(0, 1) == 0)
			pri = PriW'($urandom_range(0, 255));
		else
			pri = PriW'($urandom_range(0, 3) * 85);
		offer(mode, IdW'($urandom_range(0, 255)), pri);
	endtask

	initial begin
		int unsigned sent;
		int unsigned seg_len;
		int unsigned insert_pct;
		int unsigned k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: remove from empty, field extremes, a tie group, then drain past empty.
		offer(prq_pkg::MODE_REMOVE, 8'h00, 8'h00);
		offer(prq_pkg::MODE_INSERT, 8'h00, 8'h00);
		offer(prq_pkg::MODE_INSERT, 8'hFF, 8'hFF);
		offer(prq_pkg::MODE_INSERT, 8'h01, 8'h80);
		offer(prq_pkg::MODE_INSERT, 8'h02, 8'h80);
		offer(prq_pkg::MODE_INSERT, 8'h03, 8'h80);
		offer(prq_pkg::MODE_INSERT, 8'hA5, 8'h5A);
		offer(prq_pkg::MODE_INSERT, 8'h5A, 8'hA5);
		for (k = 0; k < 9; k++)
			offer(prq_pkg::MODE_REMOVE, 8'hFF, 8'hFF);
		drain_results();

		// Random: segments leaning to inserts, removes or neither, so the queue
		// fills and empties repeatedly.
		sent = 0;
		hold_request = 1'b1;
		while (sent < RandomOps) begin
			seg_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: insert_pct = 90;
				1: insert_pct = 50;
				default: insert_pct = 15;
			endcase
			for (k = 0; k < seg_len && sent < RandomOps; k++) begin
				random_op(insert_pct);
				sent++;
			end
			if (sent > RandomOps / 2 && sent <= RandomOps / 2 + 60)
				hold_request = 1'b1;
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (model.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
src/prq_pkg.sv
src/prq_cell.sv
src/priority_ready_queue.sv
tb/priority_ready_queue_test.sv
